FILE: rtl/lcw_pkg.sv
// Shared constants, types and handshake structures of the line clipping block.
package lcw_pkg;

    localparam int CW         = 16;
    localparam int MAX_PASSES = 8;
    localparam int SIZE_W     = 14;
    localparam int CFG_IDX_W  = 1;

    // Internal coordinate width holds the window edges and the original points.
    localparam int IW = ((CW > SIZE_W) ? CW : SIZE_W) + 2;
    // Magnitude width of differences and of the quotient.
    localparam int QW = CW + 1;
    localparam int PW = 2 * QW;

    localparam int PASS_W = $clog2(MAX_PASSES + 1);
    localparam int DIV_W  = $clog2(QW);

    localparam logic [3:0] OC_LEFT   = 4'd1;
    localparam logic [3:0] OC_RIGHT  = 4'd2;
    localparam logic [3:0] OC_BOTTOM = 4'd4;
    localparam logic [3:0] OC_TOP    = 4'd8;

    localparam logic [CFG_IDX_W-1:0] REG_WIN_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_WIN_HEIGHT = CFG_IDX_W'(1);

    localparam logic [SIZE_W-1:0] WIN_SIZE_RESET = SIZE_W'(1024);

    typedef logic signed [CW-1:0] coord_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MULT,
        ST_LOAD,
        ST_DIV,
        ST_UPDATE,
        ST_FINISH
    } clip_state_t;

    typedef struct packed {
        logic load_in;
        logic setup;
        logic mul;
        logic div_load;
        logic div_step;
        logic update;
        logic finish;
        logic visible;
    } clip_cmd_t;

    typedef struct packed {
        logic all_in;
        logic share;
        logic out_free;
    } clip_status_t;

endpackage

FILE: rtl/lcw_in_if.sv
// Input channel carrying one line segment per item.
interface lcw_in_if
    import lcw_pkg::*;
;
    logic   valid;
    logic   ready;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;

    modport source (output valid, output start_x, output start_y, output end_x,
                    output end_y, input ready);
    modport sink   (input valid, input start_x, input start_y, input end_x,
                    input end_y, output ready);
endinterface

FILE: rtl/lcw_out_if.sv
// Output channel carrying one clipped segment per item.
interface lcw_out_if
    import lcw_pkg::*;
;
    logic   valid;
    logic   ready;
    logic   visible;
    coord_t clip_start_x;
    coord_t clip_start_y;
    coord_t clip_end_x;
    coord_t clip_end_y;

    modport source (output valid, output visible, output clip_start_x,
                    output clip_start_y, output clip_end_x, output clip_end_y,
                    input ready);
    modport sink   (input valid, input visible, input clip_start_x,
                    input clip_start_y, input clip_end_x, input clip_end_y,
                    output ready);
endinterface

FILE: rtl/line_clip_to_window_core.sv
// Top level of the line clipping block: controller, datapath and channel wiring.
//
//   Channel   Direction  Carries
//   in_item   sink       start_x, start_y, end_x, end_y (one segment per item)
//   out_item  source     visible, clip_start_x/y, clip_end_x/y (one per item)
//   cfg       write      cfg_we, cfg_index, cfg_data (window width and height)
//
// An item runs through P clipping passes, where P is 0 to 8; each pass is
// dominated by the 17-step bit-serial divider.
// Reset sets both window registers to 1024 and empties the output register.
// A new item is taken while a finished result still waits in the output
// register; the result of that item is held until the output register frees.
module line_clip_to_window_core
    import lcw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_data,
    lcw_in_if.sink               in_item,
    lcw_out_if.source            out_item
);

    clip_cmd_t    cmd;
    clip_status_t status;
    logic         in_ready;

    assign in_item.ready = in_ready;

    lcw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_item.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    lcw_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .start_x      (in_item.start_x),
        .start_y      (in_item.start_y),
        .end_x        (in_item.end_x),
        .end_y        (in_item.end_y),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (out_item.valid),
        .out_ready    (out_item.ready),
        .visible      (out_item.visible),
        .clip_start_x (out_item.clip_start_x),
        .clip_start_y (out_item.clip_start_y),
        .clip_end_x   (out_item.clip_end_x),
        .clip_end_y   (out_item.clip_end_y)
    );

endmodule

FILE: rtl/lcw_ctrl.sv
// Sequencer of the clipping passes, the multiply and the serial division.
module lcw_ctrl
    import lcw_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  clip_status_t status,
    output clip_cmd_t    cmd
);

    clip_state_t       state_reg, state_next;
    logic [PASS_W-1:0] pass_reg, pass_next;
    logic [DIV_W-1:0]  div_cnt_reg, div_cnt_next;
    logic              vis_reg, vis_next;
    logic              cap_hit;

    assign cap_hit = (pass_reg == PASS_W'(MAX_PASSES));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pass_reg    <= '0;
            div_cnt_reg <= '0;
            vis_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pass_reg    <= pass_next;
            div_cnt_reg <= div_cnt_next;
            vis_reg     <= vis_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        pass_next    = pass_reg;
        div_cnt_next = div_cnt_reg;
        vis_next     = vis_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EVAL;
                    pass_next  = '0;
                end
            end
            ST_EVAL:
            begin
                if (cap_hit || (!status.all_in && status.share))
                begin
                    vis_next   = 1'b0;
                    state_next = ST_FINISH;
                end
                else if (status.all_in)
                begin
                    vis_next   = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_MULT;
                end
            end
            ST_MULT:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                div_cnt_next = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_W'(QW - 1))
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                pass_next  = pass_reg + 1'b1;
                state_next = ST_EVAL;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            ST_EVAL:
            begin
                cmd.setup = !cap_hit && !status.all_in && !status.share;
            end
            ST_MULT:
            begin
                cmd.mul = 1'b1;
            end
            ST_LOAD:
            begin
                cmd.div_load = 1'b1;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.finish  = status.out_free;
                cmd.visible = vis_reg;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: rtl/lcw_datapath.sv
// Endpoint registers, outcodes, edge intersection arithmetic and result register.
module lcw_datapath
    import lcw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_data,
    input  coord_t               start_x,
    input  coord_t               start_y,
    input  coord_t               end_x,
    input  coord_t               end_y,
    input  clip_cmd_t            cmd,
    output clip_status_t         status,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 visible,
    output coord_t               clip_start_x,
    output coord_t               clip_start_y,
    output coord_t               clip_end_x,
    output coord_t               clip_end_y
);

    logic [SIZE_W-1:0] w_reg, h_reg;

    logic signed [IW-1:0] x0_reg, y0_reg, x1_reg, y1_reg;
    logic signed [IW-1:0] edge_reg, edge_next;
    logic [QW-1:0]        mag_a_reg, mag_b_reg, mag_d_reg;
    logic                 neg_reg, vert_reg, sel_reg;
    logic [PW-1:0]        prod_reg;
    logic [QW-1:0]        rem_reg, quo_reg;
    logic                 out_valid_reg;
    logic                 vis_reg;
    coord_t               sx_reg, sy_reg, ex_reg, ey_reg;

    logic signed [IW-1:0] wi, hi;
    logic [3:0]           c0, c1, csel;
    logic                 vert_next, sel_next;
    logic signed [IW:0]   a_val, b_val, d_val;
    logic [QW:0]          trial;
    logic signed [IW-1:0] quo_s, new_c;

    function automatic logic [3:0] outcode(input logic signed [IW-1:0] x,
                                           input logic signed [IW-1:0] y,
                                           input logic signed [IW-1:0] wv,
                                           input logic signed [IW-1:0] hv);
        logic [3:0] c;
        c = 4'd0;
        if (x < 0)
        begin
            c = c | OC_LEFT;
        end
        else if (x >= wv)
        begin
            c = c | OC_RIGHT;
        end
        if (y < 0)
        begin
            c = c | OC_BOTTOM;
        end
        else if (y >= hv)
        begin
            c = c | OC_TOP;
        end
        return c;
    endfunction

    function automatic logic [QW-1:0] magnitude(input logic signed [IW:0] v);
        logic signed [IW:0] m;
        m = (v < 0) ? -v : v;
        return m[QW-1:0];
    endfunction

    assign wi = signed'({{(IW - SIZE_W){1'b0}}, w_reg});
    assign hi = signed'({{(IW - SIZE_W){1'b0}}, h_reg});
    assign c0 = outcode(x0_reg, y0_reg, wi, hi);
    assign c1 = outcode(x1_reg, y1_reg, wi, hi);

    assign status.all_in   = ((c0 | c1) == 4'd0);
    assign status.share    = ((c0 & c1) != 4'd0);
    assign status.out_free = !out_valid_reg || out_ready;

    // Pick the first outside endpoint and the edge it is moved onto.
    always_comb
    begin
        sel_next  = (c0 == 4'd0);
        csel      = sel_next ? c1 : c0;
        vert_next = ((csel & (OC_TOP | OC_BOTTOM)) != 4'd0);
        if (vert_next)
        begin
            edge_next = ((csel & OC_TOP) != 4'd0) ? (hi - 1'b1) : '0;
            a_val     = (IW + 1)'(x1_reg) - (IW + 1)'(x0_reg);
            b_val     = (IW + 1)'(edge_next) - (IW + 1)'(y0_reg);
            d_val     = (IW + 1)'(y1_reg) - (IW + 1)'(y0_reg);
        end
        else
        begin
            edge_next = ((csel & OC_RIGHT) != 4'd0) ? (wi - 1'b1) : '0;
            a_val     = (IW + 1)'(y1_reg) - (IW + 1)'(y0_reg);
            b_val     = (IW + 1)'(edge_next) - (IW + 1)'(x0_reg);
            d_val     = (IW + 1)'(x1_reg) - (IW + 1)'(x0_reg);
        end
        if (d_val == 0)
        begin
            d_val = (IW + 1)'(1);
        end
    end

    // One restoring division step per cycle.
    assign trial = {rem_reg, quo_reg[QW-1]} - {1'b0, mag_d_reg};

    assign quo_s = neg_reg ? -signed'(IW'(quo_reg)) : signed'(IW'(quo_reg));
    assign new_c = (vert_reg ? x0_reg : y0_reg) + quo_s;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg         <= WIN_SIZE_RESET;
            h_reg         <= WIN_SIZE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_WIN_WIDTH:  w_reg <= cfg_data;
                    REG_WIN_HEIGHT: h_reg <= cfg_data;
                    default:        w_reg <= w_reg;
                endcase
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            x0_reg <= IW'(start_x);
            y0_reg <= IW'(start_y);
            x1_reg <= IW'(end_x);
            y1_reg <= IW'(end_y);
        end
        else if (cmd.update)
        begin
            if (sel_reg)
            begin
                x1_reg <= vert_reg ? new_c : edge_reg;
                y1_reg <= vert_reg ? edge_reg : new_c;
            end
            else
            begin
                x0_reg <= vert_reg ? new_c : edge_reg;
                y0_reg <= vert_reg ? edge_reg : new_c;
            end
        end
        if (cmd.setup)
        begin
            sel_reg   <= sel_next;
            vert_reg  <= vert_next;
            edge_reg  <= edge_next;
            mag_a_reg <= magnitude(a_val);
            mag_b_reg <= magnitude(b_val);
            mag_d_reg <= magnitude(d_val);
            neg_reg   <= a_val[IW] ^ b_val[IW] ^ d_val[IW];
        end
        if (cmd.mul)
        begin
            prod_reg <= PW'(mag_a_reg) * PW'(mag_b_reg);
        end
        if (cmd.div_load)
        begin
            rem_reg <= prod_reg[PW-1:QW];
            quo_reg <= prod_reg[QW-1:0];
        end
        else if (cmd.div_step)
        begin
            if (!trial[QW])
            begin
                rem_reg <= trial[QW-1:0];
                quo_reg <= {quo_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[QW-2:0], quo_reg[QW-1]};
                quo_reg <= {quo_reg[QW-2:0], 1'b0};
            end
        end
        if (cmd.finish)
        begin
            vis_reg <= cmd.visible;
            sx_reg  <= cmd.visible ? x0_reg[CW-1:0] : '0;
            sy_reg  <= cmd.visible ? y0_reg[CW-1:0] : '0;
            ex_reg  <= cmd.visible ? x1_reg[CW-1:0] : '0;
            ey_reg  <= cmd.visible ? y1_reg[CW-1:0] : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign visible      = vis_reg;
    assign clip_start_x = sx_reg;
    assign clip_start_y = sy_reg;
    assign clip_end_x   = ex_reg;
    assign clip_end_y   = ey_reg;

endmodule
